/* hw/rtl/jddm_pkg.sv */
// Shared constants and widths for the joystick differential drive mixer.
package jddm_pkg;

  // Fixed point format of unit fractions: FRAC_BITS fraction bits, one integer bit.
  localparam int FRAC_BITS = 16;
  localparam int NORM_W    = FRAC_BITS + 1;
  localparam logic [NORM_W-1:0] NORM_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Field widths.
  localparam int AXIS_W = 16;
  localparam int FS_W   = 15;
  localparam int DUTY_W = 16;
  localparam int DIR_W  = 2;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;

  // The normalizing divider produces FRAC_BITS quotient bits over DIV_STAGES stages.
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = (FRAC_BITS + DIV_STAGES - 1) / DIV_STAGES;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_LIMIT = 2'd2;

  // Register reset values.
  localparam logic [FS_W-1:0]   FULL_SCALE_RST = 15'd32767;
  localparam logic [DUTY_W-1:0] LIMIT_RST      = 16'd65535;

  // Wheel direction codes.
  localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_BACK = 2'd2;

endpackage

/* hw/rtl/jddm_norm.sv */
// Pipelined restoring divider that normalizes an axis magnitude to a unit fraction.
module jddm_norm (
  input  logic                          clk,
  input  logic [jddm_pkg::FS_W-1:0]     fs,
  input  logic [jddm_pkg::FS_W-1:0]     rem_in,
  input  logic                          sat_in,
  output logic [jddm_pkg::NORM_W-1:0]   norm_out
);
  import jddm_pkg::*;

  logic [FS_W-1:0]      rem_r   [DIV_STAGES];
  logic [FRAC_BITS-1:0] quo_r   [DIV_STAGES];
  logic                 sat_r   [DIV_STAGES];
  logic [FS_W-1:0]      rem_nxt [DIV_STAGES];
  logic [FRAC_BITS-1:0] quo_nxt [DIV_STAGES];
  logic [FS_W-1:0]      rem_src [DIV_STAGES];
  logic [FRAC_BITS-1:0] quo_src [DIV_STAGES];
  logic                 sat_src [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    // Each stage takes the partial remainder of the stage before it.
    if (s == 0) begin : g_first
      assign rem_src[s] = rem_in;
      assign quo_src[s] = '0;
      assign sat_src[s] = sat_in;
    end else begin : g_next
      assign rem_src[s] = rem_r[s-1];
      assign quo_src[s] = quo_r[s-1];
      assign sat_src[s] = sat_r[s-1];
    end

    // DIV_STEPS quotient bits per stage, most significant first.
    always_comb begin
      logic [FS_W:0]        shifted;
      logic [FS_W-1:0]      rem_v;
      logic [FRAC_BITS-1:0] quo_v;
      rem_v   = rem_src[s];
      quo_v   = quo_src[s];
      shifted = '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (s * DIV_STEPS + j < FRAC_BITS) begin
          shifted = {rem_v, 1'b0};
          if (shifted >= {1'b0, fs}) begin
            rem_v = FS_W'(shifted - {1'b0, fs});
            quo_v = {quo_v[FRAC_BITS-2:0], 1'b1};
          end else begin
            rem_v = shifted[FS_W-1:0];
            quo_v = {quo_v[FRAC_BITS-2:0], 1'b0};
          end
        end
      end
      rem_nxt[s] = rem_v;
      quo_nxt[s] = quo_v;
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt[s];
      quo_r[s] <= quo_nxt[s];
      sat_r[s] <= sat_src[s];
    end
  end

  // A magnitude at or above full scale maps to exactly one.
  assign norm_out = sat_r[DIV_STAGES-1] ? NORM_ONE : {1'b0, quo_r[DIV_STAGES-1]};

endmodule

/* hw/rtl/joystick_differential_drive_mixer.sv */
// Top level of the joystick differential drive mixer: one sample in, one wheel command out.
// The result strobe out_valid is high for one cycle per item, once the item has passed
// stages A and B, the divider stages, stage M, stage S and the output registers.
// Throughput: one item per cycle; busy stays low, and the four-stage divider and the two
// multiplier stages are fully pipelined.
// Reset clears all valid bits and loads full scale 32767 and both duty limits 65535.
module joystick_differential_drive_mixer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [jddm_pkg::AXIS_W-1:0] in_turn_axis,
  input  logic signed [jddm_pkg::AXIS_W-1:0] in_drive_axis,
  input  logic                            cfg_we,
  input  logic [jddm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jddm_pkg::CFG_W-1:0]      cfg_data,
  output logic                            out_valid,
  output logic [jddm_pkg::DUTY_W-1:0]     out_left_duty,
  output logic [jddm_pkg::DUTY_W-1:0]     out_right_duty,
  output logic [jddm_pkg::DIR_W-1:0]      out_left_direction,
  output logic [jddm_pkg::DIR_W-1:0]      out_right_direction
);
  import jddm_pkg::*;

  typedef struct packed {
    logic tneg;
    logic dneg;
    logic tzero;
    logic dzero;
    logic sharp;
  } mix_flags_t;

  // Configuration registers.
  logic [FS_W-1:0]   fs_r;
  logic [DUTY_W-1:0] left_limit_r;
  logic [DUTY_W-1:0] right_limit_r;
  logic [FS_W-1:0]   fs_eff;

  // Stage A: magnitudes and signs.
  logic              a_valid_r;
  logic [AXIS_W-1:0] a_tmag_r, a_dmag_r;
  logic              a_tneg_r, a_dneg_r;
  logic [AXIS_W-1:0] turn_raw, drive_raw;

  // Stage B: dead zone, saturation and sharp turn tests.
  logic              b_valid_r;
  mix_flags_t        b_flags_r, b_flags_nxt;
  logic [FS_W-1:0]   b_trem_r, b_trem_nxt, b_drem_r, b_drem_nxt;
  logic              b_tsat_r, b_tsat_nxt, b_dsat_r, b_dsat_nxt;

  // Flags riding along the divider.
  logic              dv_valid_r [DIV_STAGES];
  mix_flags_t        dv_flags_r [DIV_STAGES];
  logic [NORM_W-1:0] turn_norm, drive_norm;

  // Stage M: inner wheel slowdown product.
  logic              m_valid_r;
  mix_flags_t        m_flags_r;
  logic [NORM_W-1:0] m_turn_r, m_drive_r, m_slow_r;
  logic [2*NORM_W-1:0] slow_prod;

  // Stage S: wheel speeds and directions.
  logic              s_valid_r;
  logic [NORM_W-1:0] s_ls_r, s_rs_r, s_ls_nxt, s_rs_nxt;
  logic [DIR_W-1:0]  s_ld_r, s_rd_r, s_ld_nxt, s_rd_nxt;

  // Output registers.
  logic              out_valid_r;
  logic [DUTY_W-1:0] out_left_duty_r, out_right_duty_r;
  logic [DIR_W-1:0]  out_left_dir_r, out_right_dir_r;
  logic [NORM_W+DUTY_W-1:0] left_prod, right_prod;

  // The pipeline never stalls, so an item is taken in every cycle.
  assign busy = 1'b0;

  // Configuration write decode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r          <= FULL_SCALE_RST;
      left_limit_r  <= LIMIT_RST;
      right_limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FULL_SCALE:  fs_r          <= cfg_data[FS_W-1:0];
        CFG_LEFT_LIMIT:  left_limit_r  <= cfg_data[DUTY_W-1:0];
        CFG_RIGHT_LIMIT: right_limit_r <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // A full scale of zero behaves as one.
  assign fs_eff = (fs_r == '0) ? FS_W'(1) : fs_r;

  // Stage A: take the magnitude of each axis.
  assign turn_raw  = in_turn_axis;
  assign drive_raw = in_drive_axis;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_tneg_r <= turn_raw[AXIS_W-1];
    a_dneg_r <= drive_raw[AXIS_W-1];
    a_tmag_r <= turn_raw[AXIS_W-1] ? (~turn_raw + AXIS_W'(1)) : turn_raw;
    a_dmag_r <= drive_raw[AXIS_W-1] ? (~drive_raw + AXIS_W'(1)) : drive_raw;
  end

  // Stage B: dead zone at 0.2, clamp at full scale, sharp turn above 0.7.
  always_comb begin
    logic [AXIS_W+1:0] t5, d5;
    logic              tdead, ddead, tsat, dsat;
    logic [FS_W-1:0]   tclamp;
    logic [FS_W+3:0]   t10, fs7;
    t5     = (AXIS_W+2)'(a_tmag_r) + ((AXIS_W+2)'(a_tmag_r) << 2);
    d5     = (AXIS_W+2)'(a_dmag_r) + ((AXIS_W+2)'(a_dmag_r) << 2);
    tdead  = t5 < (AXIS_W+2)'(fs_eff);
    ddead  = d5 < (AXIS_W+2)'(fs_eff);
    tsat   = a_tmag_r >= AXIS_W'(fs_eff);
    dsat   = a_dmag_r >= AXIS_W'(fs_eff);
    tclamp = tsat ? fs_eff : a_tmag_r[FS_W-1:0];
    t10    = ((FS_W+4)'(tclamp) << 3) + ((FS_W+4)'(tclamp) << 1);
    fs7    = ((FS_W+4)'(fs_eff) << 3) - (FS_W+4)'(fs_eff);

    b_flags_nxt.tneg  = a_tneg_r;
    b_flags_nxt.dneg  = a_dneg_r;
    b_flags_nxt.tzero = tdead;
    b_flags_nxt.dzero = ddead;
    b_flags_nxt.sharp = t10 > fs7;
    b_tsat_nxt = tsat && !tdead;
    b_dsat_nxt = dsat && !ddead;
    b_trem_nxt = (tdead || tsat) ? '0 : a_tmag_r[FS_W-1:0];
    b_drem_nxt = (ddead || dsat) ? '0 : a_dmag_r[FS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    b_flags_r <= b_flags_nxt;
    b_trem_r  <= b_trem_nxt;
    b_drem_r  <= b_drem_nxt;
    b_tsat_r  <= b_tsat_nxt;
    b_dsat_r  <= b_dsat_nxt;
  end

  // Normalize both axes in parallel.
  jddm_norm u_turn_norm (
    .clk      (clk),
    .fs       (fs_eff),
    .rem_in   (b_trem_r),
    .sat_in   (b_tsat_r),
    .norm_out (turn_norm)
  );

  jddm_norm u_drive_norm (
    .clk      (clk),
    .fs       (fs_eff),
    .rem_in   (b_drem_r),
    .sat_in   (b_dsat_r),
    .norm_out (drive_norm)
  );

  // Carry the flags and valid bits alongside the divider stages.
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_flag_pipe
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_valid_r[s] <= 1'b0;
        end else begin
          dv_valid_r[s] <= b_valid_r;
        end
      end
      always_ff @(posedge clk) begin
        dv_flags_r[s] <= b_flags_r;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_valid_r[s] <= 1'b0;
        end else begin
          dv_valid_r[s] <= dv_valid_r[s-1];
        end
      end
      always_ff @(posedge clk) begin
        dv_flags_r[s] <= dv_flags_r[s-1];
      end
    end
  end

  // Stage M: inner wheel speed drive * (1 - turn).
  assign slow_prod = drive_norm * (NORM_ONE - turn_norm);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= dv_valid_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    m_flags_r <= dv_flags_r[DIV_STAGES-1];
    m_turn_r  <= turn_norm;
    m_drive_r <= drive_norm;
    m_slow_r  <= slow_prod[FRAC_BITS+NORM_W-1:FRAC_BITS];
  end

  // Stage S: pick the speed and direction of each wheel.
  always_comb begin
    logic [DIR_W-1:0]  base_dir, flip_dir;
    logic [NORM_W-1:0] inner;
    base_dir = m_flags_r.dneg ? DIR_BACK : DIR_FWD;
    flip_dir = m_flags_r.dneg ? DIR_FWD : DIR_BACK;
    inner    = m_flags_r.sharp ? (m_turn_r >> 1) : m_slow_r;
    s_ls_nxt = '0;
    s_rs_nxt = '0;
    s_ld_nxt = DIR_STOP;
    s_rd_nxt = DIR_STOP;
    if (m_flags_r.dzero) begin
      // No drive: spin in place when there is a turn.
      if (!m_flags_r.tzero) begin
        s_ls_nxt = m_turn_r;
        s_rs_nxt = m_turn_r;
        s_ld_nxt = m_flags_r.tneg ? DIR_BACK : DIR_FWD;
        s_rd_nxt = m_flags_r.tneg ? DIR_FWD : DIR_BACK;
      end
    end else begin
      s_ls_nxt = m_drive_r;
      s_rs_nxt = m_drive_r;
      s_ld_nxt = base_dir;
      s_rd_nxt = base_dir;
      // Slow or reverse the wheel on the inner side of the turn.
      if (!m_flags_r.tzero) begin
        if (m_flags_r.tneg) begin
          s_ls_nxt = inner;
          if (m_flags_r.sharp) begin
            s_ld_nxt = flip_dir;
          end
        end else begin
          s_rs_nxt = inner;
          if (m_flags_r.sharp) begin
            s_rd_nxt = flip_dir;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s_ls_r <= s_ls_nxt;
    s_rs_r <= s_rs_nxt;
    s_ld_r <= s_ld_nxt;
    s_rd_r <= s_rd_nxt;
  end

  // Output stage: scale each speed by its wheel's duty limit, truncated.
  assign left_prod  = s_ls_r * left_limit_r;
  assign right_prod = s_rs_r * right_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_left_duty_r  <= left_prod[FRAC_BITS+DUTY_W-1:FRAC_BITS];
    out_right_duty_r <= right_prod[FRAC_BITS+DUTY_W-1:FRAC_BITS];
    out_left_dir_r   <= s_ld_r;
    out_right_dir_r  <= s_rd_r;
  end

  assign out_valid           = out_valid_r;
  assign out_left_duty       = out_left_duty_r;
  assign out_right_duty      = out_right_duty_r;
  assign out_left_direction  = out_left_dir_r;
  assign out_right_direction = out_right_dir_r;

endmodule
